>>> sv/cv3_pkg.sv
package cv3_pkg;

  localparam int MAX_LINE = 1024;
  localparam int COL_W    = $clog2(MAX_LINE);
  localparam int LEN_W    = 11;
  localparam int CNT_W    = 16;
  localparam int POS_W    = 27;
  localparam int WB       = 16;
  localparam int NUM_W    = 28;
  localparam int DEN_W    = 20;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 48;

  localparam logic [IDX_W-1:0] REG_KPREV = 3'd0;
  localparam logic [IDX_W-1:0] REG_KTHIS = 3'd1;
  localparam logic [IDX_W-1:0] REG_KNEXT = 3'd2;
  localparam logic [IDX_W-1:0] REG_LEN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CNT   = 3'd4;

  localparam logic [CFG_W-1:0] KPREV_RST = 48'd4295098369;
  localparam logic [CFG_W-1:0] KTHIS_RST = 48'd8590196738;
  localparam logic [CFG_W-1:0] KNEXT_RST = 48'd4295098369;

  typedef logic [23:0] pix_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic       take;
    logic       shift;
    logic       mac;
    logic       div;
    logic       load;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic out_free;
  } sts_t;

endpackage

>>> sv/cv3_pix_if.sv
interface cv3_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

>>> sv/cv3_res_if.sv
interface cv3_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_pixel;
  logic       zero_weight;
  modport source (output valid, red_out, green_out, blue_out, last_pixel, zero_weight,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, last_pixel, zero_weight,
                output ready);
endinterface

>>> sv/cv3_cfg_if.sv
interface cv3_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/cv3_ctrl.sv
module cv3_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cv3_pkg::sts_t sts,
  output cv3_pkg::cmd_t cmd
);
  import cv3_pkg::*;

  state_t     state, state_next;
  logic [3:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (!sts.drop) state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        step_next = '0;
        state_next = sts.emit ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (step == 4'd8) begin
          step_next  = '0;
          state_next = ST_DIV;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (step == 4'd8) state_next = ST_HOLD;
        else step_next = step + 4'd1;
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

>>> sv/cv3_dp.sv
module cv3_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_kind,
  input  cv3_pkg::pix_t in_pix,
  input  cv3_pkg::cmd_t cmd,
  output cv3_pkg::sts_t sts,
  cv3_cfg_if.sink       cfg,
  cv3_res_if.source     res
);
  import cv3_pkg::*;

  logic [CFG_W-1:0] kern [3];
  logic [LEN_W-1:0] len_reg;
  logic [CNT_W-1:0] cnt_reg;
  logic [LEN_W-1:0] len_e;
  logic [CNT_W-1:0] cnt_e;

  pix_t older_mem [MAX_LINE];
  pix_t newer_mem [MAX_LINE];
  pix_t rd_old, rd_new;
  pix_t pix_r;
  pix_t win [3][3];

  logic [POS_W-1:0] pos;
  logic [COL_W-1:0] in_col, out_col;
  logic [CNT_W-1:0] in_row, out_row;
  logic             in_done;
  logic             top, bot, left, right, last_r;

  logic signed [NUM_W-1:0] num [3];
  logic signed [DEN_W-1:0] den;
  logic [NUM_W-1:0]        rem [3];
  logic [DEN_W-1:0]        dmag;
  logic [7:0]              quo [3];
  logic [2:0]              posv, satv;
  logic                    zden;

  logic geom_wr, emit, last_now;
  logic [1:0] tr, tc;
  logic use_tap;
  logic signed [WB-1:0] wt;
  pix_t tpix;
  logic [2:0] shamt;

  assign cfg.ready = 1'b1;
  assign geom_wr = cfg.valid && (cfg.index == REG_LEN || cfg.index == REG_CNT);

  always_comb begin
    len_e = len_reg;
    if (len_reg == '0) len_e = LEN_W'(1);
    else if (len_reg > LEN_W'(MAX_LINE)) len_e = LEN_W'(MAX_LINE);
    cnt_e = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kern[0] <= KPREV_RST;
      kern[1] <= KTHIS_RST;
      kern[2] <= KNEXT_RST;
      len_reg <= LEN_W'(MAX_LINE);
      cnt_reg <= CNT_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KPREV: kern[0] <= cfg.data;
        REG_KTHIS: kern[1] <= cfg.data;
        REG_KNEXT: kern[2] <= cfg.data;
        REG_LEN:   len_reg <= cfg.data[LEN_W-1:0];
        REG_CNT:   cnt_reg <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // line stores, read at the current column ahead of the shift
  always_ff @(posedge clk) begin
    rd_old <= older_mem[in_col];
    rd_new <= newer_mem[in_col];
    if (cmd.shift) begin
      older_mem[in_col] <= rd_new;
      newer_mem[in_col] <= pix_r;
    end
  end

  assign sts.drop     = !in_done && in_kind;
  assign emit         = pos >= POS_W'({1'b0, len_e} + 12'd1);
  assign sts.emit     = emit;
  assign sts.out_free = !res.valid || res.ready;
  assign last_now     = (out_row == cnt_e - CNT_W'(1))
                        && ({1'b0, out_col} == len_e - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.take) pix_r <= in_done ? '0 : in_pix;
    if (cmd.shift && emit) begin
      top    <= (out_row == '0);
      bot    <= ({1'b0, out_row} + 17'd1) >= {1'b0, cnt_e};
      left   <= (out_col == '0);
      right  <= ({1'b0, out_col} + LEN_W'(1)) >= len_e;
      last_r <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_old;
      win[1][2] <= rd_new;
      win[2][2] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      pos <= '0; in_col <= '0; in_row <= '0; in_done <= 1'b0;
      out_col <= '0; out_row <= '0;
    end else if (cmd.shift) begin
      if (emit && last_now) begin
        pos <= '0; in_col <= '0; in_row <= '0; in_done <= 1'b0;
        out_col <= '0; out_row <= '0;
      end else begin
        pos <= pos + POS_W'(1);
        if ({1'b0, in_col} == len_e - LEN_W'(1)) begin
          in_col <= '0;
          if (!in_done) begin
            if (in_row == cnt_e - CNT_W'(1)) in_done <= 1'b1;
            else in_row <= in_row + CNT_W'(1);
          end
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (emit) begin
          if ({1'b0, out_col} == len_e - LEN_W'(1)) begin
            out_col <= '0;
            out_row <= out_row + CNT_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  // multiply-accumulate, one tap per cycle
  always_comb begin
    case (cmd.step)
      4'd0, 4'd1, 4'd2: tr = 2'd0;
      4'd3, 4'd4, 4'd5: tr = 2'd1;
      default:          tr = 2'd2;
    endcase
    case (cmd.step)
      4'd0, 4'd3, 4'd6: tc = 2'd0;
      4'd1, 4'd4, 4'd7: tc = 2'd1;
      default:          tc = 2'd2;
    endcase
    use_tap = !(tr == 2'd0 && top) && !(tr == 2'd2 && bot)
              && !(tc == 2'd0 && left) && !(tc == 2'd2 && right);
    wt   = kern[tr][tc*16 +: WB];
    tpix = win[tr][tc];
    shamt = 3'(4'd8 - cmd.step);
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < 3; k++) num[k] <= '0;
      den <= '0;
    end else if (cmd.mac && use_tap) begin
      for (int k = 0; k < 3; k++)
        num[k] <= num[k] + NUM_W'(wt * $signed({1'b0, tpix[16-8*k +: 8]}));
      den <= den + DEN_W'(wt);
    end
  end

  // sign fix-up, then restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div) begin
      if (cmd.step == 4'd0) begin
        logic signed [NUM_W-1:0] n;
        logic [DEN_W-1:0] d;
        d = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        dmag <= d;
        zden <= (den == '0);
        for (int k = 0; k < 3; k++) begin
          n = den[DEN_W-1] ? -num[k] : num[k];
          posv[k] <= n > 0;
          satv[k] <= NUM_W'(n) >= (NUM_W'(d) << 8);
          rem[k]  <= NUM_W'(n);
          quo[k]  <= '0;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (rem[k] >= (NUM_W'(dmag) << shamt)) begin
            rem[k]        <= rem[k] - (NUM_W'(dmag) << shamt);
            quo[k][shamt] <= 1'b1;
          end
        end
      end
    end
  end

  function automatic logic [7:0] chan(logic p, logic s, logic z, logic [7:0] q);
    if (z || !p) return 8'd0;
    if (s) return 8'd255;
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (cmd.load) res.valid <= 1'b1;
    else if (res.ready) res.valid <= 1'b0;
    if (cmd.load) begin
      res.red_out     <= chan(posv[0], satv[0], zden, quo[0]);
      res.green_out   <= chan(posv[1], satv[1], zden, quo[1]);
      res.blue_out    <= chan(posv[2], satv[2], zden, quo[2]);
      res.zero_weight <= zden;
      res.last_pixel  <= last_r;
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.zero_weight |->
      res.red_out == 8'd0 && res.green_out == 8'd0 && res.blue_out == 8'd0)
    else $error("zero weight result with non-zero channels");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_col} < len_e || $past(geom_wr))
    else $error("input column beyond line length");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(cmd.load))
    else $error("result valid without load");

endmodule

>>> sv/rgb_conv3x3_border_renorm.sv
// channel   dir  beat carries
// pixels    in   kind, red_in, green_in, blue_in
// results   out  red_out, green_out, blue_out, last_pixel, zero_weight
// cfg       in   index, data (register write)
// An item that yields a result passes take, shift, nine MAC taps, nine
// divide steps and load; one that yields none passes take and shift, an
// early drain only take; the serial tap MAC and bit-serial divider dominate.
// Reset clears the counters and window; line stores are not cleared.
// A held result waits in the output register while the next item is taken.
module rgb_conv3x3_border_renorm (
  input logic   clk,
  input logic   rst,
  cv3_pix_if.sink   pixels,
  cv3_res_if.source results,
  cv3_cfg_if.sink   cfg
);
  import cv3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cv3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cv3_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_kind (pixels.kind),
    .in_pix  ({pixels.red_in, pixels.green_in, pixels.blue_in}),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg),
    .res     (results)
  );

endmodule

>>> tb/tb_rgb_conv3x3_border_renorm.sv
module tb_rgb_conv3x3_border_renorm;
  timeunit 1ns;
  timeprecision 1ps;
  import cv3_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;  // unmapped index, write is ignored
  localparam bit DRAIN   = 1'b1;
  localparam bit PIXEL   = 1'b0;
  localparam int SETTLE  = 60;
  localparam int LIMIT   = 3000000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       zero_w;
  } filt_pix_t;

  class conv_scoreboard;
    logic [CFG_W-1:0] kern [3];
    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] cnt_reg;
    pix_t             older [MAX_LINE];
    pix_t             newer [MAX_LINE];
    pix_t             win   [9];
    longint           in_pos;
    filt_pix_t        want [$];
    int               errors;

    function new();
      kern[0] = KPREV_RST;
      kern[1] = KTHIS_RST;
      kern[2] = KNEXT_RST;
      len_reg = 11'd1024;
      cnt_reg = 16'd1;
      foreach (older[i]) begin
        older[i] = '0;
        newer[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_KPREV: kern[0] = d;
        REG_KTHIS: kern[1] = d;
        REG_KNEXT: kern[2] = d;
        REG_LEN: begin
          len_reg = d[LEN_W-1:0];
          in_pos = 0;
        end
        REG_CNT: begin
          cnt_reg = d[CNT_W-1:0];
          in_pos = 0;
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] renorm(longint num, longint den);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) return 8'd0;
      num = num / den;
      return (num > 255) ? 8'd255 : num[7:0];
    endfunction

    function void note_pixel(bit kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      longint len, cnt, total, p, col, o, ro, co, den, w;
      longint num [3];
      pix_t pix, px;
      filt_pix_t res;
      len = (len_reg == 0) ? 1 : ((len_reg > MAX_LINE) ? MAX_LINE : len_reg);
      cnt = (cnt_reg == 0) ? 1 : cnt_reg;
      total = len * cnt;
      p = in_pos;
      pix = '0;
      if (p < total) begin
        if (kind) return;  // drain before the image is complete
        pix = {r, g, b};
      end
      col = p % len;
      for (int i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = older[col];
      win[5] = newer[col];
      win[8] = pix;
      older[col] = newer[col];
      newer[col] = pix;
      in_pos = p + 1;
      if (p < len + 1) return;
      o = p - len - 1;
      if (o >= total) begin
        in_pos = 0;
        return;
      end
      ro = o / len;
      co = o % len;
      den = 0;
      num[0] = 0; num[1] = 0; num[2] = 0;
      for (int i = 0; i < 3; i++) begin
        if (i == 0 && ro == 0) continue;
        if (i == 2 && ro + 1 >= cnt) continue;
        for (int j = 0; j < 3; j++) begin
          if (j == 0 && co == 0) continue;
          if (j == 2 && co + 1 >= len) continue;
          w = $signed(kern[i][16*j +: 16]);
          px = win[i*3+j];
          den += w;
          num[0] += w * longint'(px[23:16]);
          num[1] += w * longint'(px[15:8]);
          num[2] += w * longint'(px[7:0]);
        end
      end
      res.zero_w = (den == 0);
      res.red    = res.zero_w ? 8'd0 : renorm(num[0], den);
      res.green  = res.zero_w ? 8'd0 : renorm(num[1], den);
      res.blue   = res.zero_w ? 8'd0 : renorm(num[2], den);
      res.last   = (o + 1 == total);
      if (res.last) in_pos = 0;
      want.push_back(res);
    endfunction

    function void check_result(filt_pix_t got);
      filt_pix_t exp_r;
      if (want.size() == 0) begin
        $display("%0t: unexpected result beat r=%0d g=%0d b=%0d last=%0b zw=%0b", $time,
                 got.red, got.green, got.blue, got.last, got.zero_w);
        errors++;
        return;
      end
      exp_r = want.pop_front();
      if (got.red !== exp_r.red)
        $display("%0t: red expected %0d actual %0d", $time, exp_r.red, got.red);
      if (got.green !== exp_r.green)
        $display("%0t: green expected %0d actual %0d", $time, exp_r.green, got.green);
      if (got.blue !== exp_r.blue)
        $display("%0t: blue expected %0d actual %0d", $time, exp_r.blue, got.blue);
      if (got.last !== exp_r.last)
        $display("%0t: last_pixel expected %0b actual %0b", $time, exp_r.last, got.last);
      if (got.zero_w !== exp_r.zero_w)
        $display("%0t: zero_weight expected %0b actual %0b", $time, exp_r.zero_w, got.zero_w);
      if (got.red !== exp_r.red || got.green !== exp_r.green || got.blue !== exp_r.blue ||
          got.last !== exp_r.last || got.zero_w !== exp_r.zero_w)
        errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  cv3_pix_if pix ();
  cv3_res_if res ();
  cv3_cfg_if cfg ();

  rgb_conv3x3_border_renorm dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix.sink),
    .results (res.source),
    .cfg     (cfg.sink)
  );

  conv_scoreboard sb;
  int send_idle;
  int recv_stall;
  bit hold_req;
  int hold_left;
  int pixels_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls plus a single long hold-off
  initial begin
    res.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res.ready = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        res.ready = 1'b0;
      end else begin
        res.ready = ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    filt_pix_t got;
    if (!rst && res.valid && res.ready) begin
      got.red    = res.red_out;
      got.green  = res.green_out;
      got.blue   = res.blue_out;
      got.last   = res.last_pixel;
      got.zero_w = res.zero_weight;
      sb.check_result(got);
    end
  end

  task automatic send_item(bit kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid    = 1'b1;
    pix.kind     = kind;
    pix.red_in   = r;
    pix.green_in = g;
    pix.blue_in  = b;
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(kind, r, g, b);
    if (kind == PIXEL) pixels_sent++;
    @(negedge clk);
    pix.valid = 1'b0;
  endtask

  task automatic send_rand_pixel();
    send_item(PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic send_rand_drain();
    send_item(DRAIN, 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic wait_drained();
    while (sb.want.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = d;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_geometry(logic [LEN_W-1:0] len, logic [CNT_W-1:0] cnt);
    // junk in the unused upper data bits, the block keeps only the low ones
    write_reg(REG_LEN, (CFG_W'({$urandom(), $urandom()}) & ~48'h7FF) | CFG_W'(len));
    write_reg(REG_CNT, (CFG_W'({$urandom(), $urandom()}) & ~48'hFFFF) | CFG_W'(cnt));
  endtask

  function automatic logic [15:0] rand_weight(int mode);
    case (mode)
      0: return 16'($signed($urandom_range(0, 9)) - 3);
      1: return 16'($urandom());
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          3: return 16'h0000;
          default: return 16'h0001;
        endcase
      end
    endcase
  endfunction

  task automatic rand_kernels();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      // rows sum to zero in the interior and at top and bottom, not at left and right
      write_reg(REG_KPREV, {16'h0001, 16'hFFFE, 16'h0001});
      write_reg(REG_KTHIS, {16'h0002, 16'hFFFC, 16'h0002});
      write_reg(REG_KNEXT, {16'h0001, 16'hFFFE, 16'h0001});
    end else begin
      mode = (mode < 6) ? 0 : ((mode < 8) ? 1 : 2);
      write_reg(REG_KPREV, {rand_weight(mode), rand_weight(mode), rand_weight(mode)});
      write_reg(REG_KTHIS, {rand_weight(mode), rand_weight(mode), rand_weight(mode)});
      write_reg(REG_KNEXT, {rand_weight(mode), rand_weight(mode), rand_weight(mode)});
    end
  endtask

  // one image: pixels in raster order, occasional stray drains, then the flush
  task automatic run_image(int len, int cnt, bit pause_mid);
    int n;
    n = len * cnt;
    if ($urandom_range(0, 3) == 0) send_rand_drain();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_rand_drain();
      if (pause_mid && i == n / 2) begin
        while (sb.want.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_rand_pixel();
    end
    // pixels past the end flush like drains
    for (int i = 0; i <= len; i++) begin
      if ($urandom_range(0, 4) == 0) send_rand_pixel();
      else send_rand_drain();
    end
  endtask

  initial begin
    int phase;
    int len;
    int cnt;
    sb = new();
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.kind = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    pixels_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 3x3 image with default kernel, extremes of the channels
    set_geometry(3, 3);
    send_item(DRAIN, 8'hFF, 8'hFF, 8'hFF);
    send_item(PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(PIXEL, 8'hFF, 8'h00, 8'hFF);
    send_item(PIXEL, 8'h00, 8'hFF, 8'h00);
    send_item(PIXEL, 8'hAA, 8'h55, 8'h0F);
    send_item(PIXEL, 8'h55, 8'hAA, 8'hF0);
    send_item(PIXEL, 8'hFF, 8'hFF, 8'h00);
    send_item(PIXEL, 8'h01, 8'h80, 8'h7F);
    send_item(PIXEL, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_item(DRAIN, 8'h00, 8'h00, 8'h00);
    wait_drained();
    // single pixel image: zero centre weight, trailing pixel acts as drain
    write_reg(REG_KTHIS, 48'h0);
    set_geometry(1, 1);
    send_item(PIXEL, 8'hC8, 8'h10, 8'h7E);
    send_item(PIXEL, 8'h12, 8'h34, 8'h56);
    send_item(DRAIN, 8'h00, 8'h00, 8'h00);
    wait_drained();
    // length 0 acts as 1, count 0 acts as 1, a lone negative weight cancels in the division
    write_reg(REG_KTHIS, {16'h0001, 16'hFFFF, 16'h0001});
    set_geometry(0, 0);
    send_item(PIXEL, 8'hFF, 8'h00, 8'h80);
    send_item(DRAIN, 8'h00, 8'h00, 8'h00);
    send_item(DRAIN, 8'h00, 8'h00, 8'h00);
    wait_drained();
    write_reg(REG_SPARE, CFG_W'({$urandom(), $urandom()}));

    // random images through the idling phases
    phase = 0;
    while (pixels_sent < 400) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      wait_drained();
      rand_kernels();
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 24);
        cnt = $urandom_range(1, 3);
      end else begin
        len = $urandom_range(1, 8);
        cnt = $urandom_range(1, 6);
      end
      set_geometry(LEN_W'(len), CNT_W'(cnt));
      if (phase == 5) begin
        set_geometry(8, 6);
        len = 8;
        cnt = 6;
        hold_req = 1'b1;
      end
      if (phase % 7 == 3 && len * cnt > 4) begin
        // abandon the image half way and restart with the same geometry
        for (int i = 0; i < len * cnt / 2; i++) send_rand_pixel();
        wait_drained();
        set_geometry(LEN_W'(len), CNT_W'(cnt));
      end
      run_image(len, cnt, phase % 5 == 2);
      phase++;
    end

    // widest line through the clamp above the maximum: a full line in,
    // the first few results out, then cut short by a new geometry
    send_idle = 0;
    recv_stall = 0;
    wait_drained();
    rand_kernels();
    set_geometry(11'h7FF, 1);
    for (int i = 0; i < 1024; i++) send_rand_pixel();
    repeat (6) send_rand_drain();
    // tallest image: a few lines only, then cut short by a new geometry
    wait_drained();
    set_geometry(1, 16'hFFFF);
    for (int i = 0; i < 12; i++) send_rand_pixel();
    wait_drained();
    set_geometry(2, 2);
    run_image(2, 2, 1'b0);

    wait_drained();
    if (sb.want.size() == 0 && sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> rgb_conv3x3_border_renorm.f
sv/cv3_pkg.sv
sv/cv3_pix_if.sv
sv/cv3_res_if.sv
sv/cv3_cfg_if.sv
sv/cv3_ctrl.sv
sv/cv3_dp.sv
sv/rgb_conv3x3_border_renorm.sv
tb/tb_rgb_conv3x3_border_renorm.sv
